// File: rtl/core/dsqd_pkg.sv
package dsqd_pkg;

  localparam int HEIGHT_BITS = 14;

  // command codes
  localparam logic [1:0] CMD_VIEWPORT = 2'd0;
  localparam logic [1:0] CMD_SET_USER = 2'd1;
  localparam logic [1:0] CMD_REQUEST  = 2'd2;
  localparam logic [1:0] CMD_CONSUME  = 2'd3;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_USER_MIN = 2'd0;
  localparam logic [1:0] REG_USER_MAX = 2'd1;
  localparam logic [1:0] REG_SETTLE   = 2'd2;

  localparam logic [9:0]  USER_MIN_RESET = 10'd128;
  localparam logic [9:0]  USER_MAX_RESET = 10'd448;
  localparam logic [7:0]  SETTLE_RESET   = 8'd12;

  localparam logic [4:0]  STEP_RESET  = 5'd6;
  localparam logic [4:0]  STEP_MIN    = 5'd3;
  localparam logic [4:0]  STEP_MAX    = 5'd18;
  localparam logic [9:0]  USER_RESET  = 10'd320;
  localparam logic [10:0] SCALE_RESET = 11'd320;
  localparam logic [10:0] SCALE_CAP   = 11'd1024;

  localparam logic [11:0] H_MIN   = 12'd540;
  localparam logic [11:0] H_MAX   = 12'd3240;
  localparam logic [11:0] HYST_PX = 12'd135;
  localparam logic [11:0] HALF_PX = 12'd90;

  // x / 6 == (x * DIV6_RECIP) >> DIV6_SHIFT, exact for x < 2**17
  localparam logic [15:0] DIV6_RECIP = 16'd43691;
  localparam int          DIV6_SHIFT = 18;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [HEIGHT_BITS-1:0] height_px;
    logic [9:0]             user_value_q8;
  } item_t;

  typedef struct packed {
    logic [10:0] scale_q8;
    logic [9:0]  user_scale_q8;
    logic [4:0]  res_sixths;
    logic        rebuild_taken;
  } result_t;

  typedef struct packed {
    logic [4:0] res_step;
    logic [4:0] pending_step;
    logic [7:0] held_count;
  } track_t;

  // pixel height of a step, step * 180
  function automatic logic [11:0] step_px(input logic [4:0] step);
    logic [11:0] px;
    case (step)
      5'd3:    px = 12'd540;
      5'd4:    px = 12'd720;
      5'd5:    px = 12'd900;
      5'd6:    px = 12'd1080;
      5'd7:    px = 12'd1260;
      5'd8:    px = 12'd1440;
      5'd9:    px = 12'd1620;
      5'd10:   px = 12'd1800;
      5'd11:   px = 12'd1980;
      5'd12:   px = 12'd2160;
      5'd13:   px = 12'd2340;
      5'd14:   px = 12'd2520;
      5'd15:   px = 12'd2700;
      5'd16:   px = 12'd2880;
      5'd17:   px = 12'd3060;
      5'd18:   px = 12'd3240;
      default: px = 12'd0;
    endcase
    return px;
  endfunction

endpackage

// File: rtl/core/display_scale_quantizer_debounce_core.sv
// Channel | Direction | Handshake                  | Payload
// item    | in        | item_valid / item_ready    | dsqd_pkg::item_t
// result  | out       | result_valid / result_ready| dsqd_pkg::result_t
// config  | in        | APB psel/penable/pready    | pwdata / prdata (32 bits)
//
// One item per cycle sustained while result is not stalled; an item reaches result
// through the input register, step/user update, and scale divide and flag stages.
// Synchronous active-high reset restores register and state defaults.
// A stall on result backs up stage by stage; empty stages still take data.
module display_scale_quantizer_debounce_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  dsqd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output dsqd_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration
  logic [9:0] user_min;
  logic [9:0] user_max;
  logic [7:0] settle;

  // input register
  dsqd_pkg::item_t item_q;
  logic            item_v;

  // stage 1 state and pipeline register
  dsqd_pkg::track_t trk;
  logic [9:0]       user_scale;
  logic             s1_v;
  logic [1:0]       s1_cmd;
  logic [14:0]      s1_prod;
  logic             s1_recomb;
  logic [9:0]       s1_user;
  logic [4:0]       s1_step;

  // stage 2 state and result register
  logic [10:0]       combined_scale;
  logic              rebuild_flag;
  dsqd_pkg::result_t res_q;
  logic              res_v;

  logic en_o;
  logic en_1;
  logic en_i;

  assign en_o         = !res_v || result_ready;
  assign en_1         = !s1_v || en_o;
  assign en_i         = !item_v || en_1;
  assign item_ready   = en_i;
  assign result_valid = res_v;
  assign result       = res_q;

  // ---------------- configuration port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      user_min <= dsqd_pkg::USER_MIN_RESET;
      user_max <= dsqd_pkg::USER_MAX_RESET;
      settle   <= dsqd_pkg::SETTLE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        dsqd_pkg::REG_USER_MIN: user_min <= pwdata[9:0];
        dsqd_pkg::REG_USER_MAX: user_max <= pwdata[9:0];
        dsqd_pkg::REG_SETTLE:   settle   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dsqd_pkg::REG_USER_MIN: prdata = {22'd0, user_min};
      dsqd_pkg::REG_USER_MAX: prdata = {22'd0, user_max};
      dsqd_pkg::REG_SETTLE:   prdata = {24'd0, settle};
      default:                prdata = 32'd0;
    endcase
  end

  // ---------------- input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (en_i) begin
      item_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && en_i) begin
      item_q <= item;
    end
  end

  // ---------------- stage 1: step tracking and user clamp
  dsqd_pkg::track_t trk_upd;
  dsqd_pkg::track_t trk_next;
  logic             adopt;
  logic [9:0]       u_cl;
  logic [9:0]       user_next;
  logic             recomb;
  logic [14:0]      prod;

  dsqd_track u_track (
    .height_px (item_q.height_px),
    .cur       (trk),
    .settle    (settle),
    .nxt       (trk_upd),
    .adopt     (adopt)
  );

  always_comb begin
    u_cl = item_q.user_value_q8;
    if (u_cl < user_min) u_cl = user_min;
    if (u_cl > user_max) u_cl = user_max;

    trk_next  = trk;
    user_next = user_scale;
    recomb    = 1'b0;
    case (item_q.cmd)
      dsqd_pkg::CMD_VIEWPORT: begin
        trk_next = trk_upd;
        recomb   = adopt;
      end
      dsqd_pkg::CMD_SET_USER: begin
        user_next = u_cl;
        recomb    = (u_cl != user_scale);
      end
      default: ;
    endcase
    prod = 15'(trk_next.res_step) * 15'(user_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trk.res_step     <= dsqd_pkg::STEP_RESET;
      trk.pending_step <= 5'd0;
      trk.held_count   <= 8'd0;
      user_scale       <= dsqd_pkg::USER_RESET;
      s1_v             <= 1'b0;
    end else begin
      if (en_1) begin
        s1_v <= item_v;
      end
      if (item_v && en_1) begin
        trk        <= trk_next;
        user_scale <= user_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_v && en_1) begin
      s1_cmd    <= item_q.cmd;
      s1_prod   <= prod;
      s1_recomb <= recomb;
      s1_user   <= user_next;
      s1_step   <= trk_next.res_step;
    end
  end

  // ---------------- stage 2: divide by six, cap, rebuild flag
  logic [30:0] p6;
  logic [12:0] quo;
  logic [10:0] scale;
  logic [10:0] comb_next;
  logic        flag_next;
  logic        taken;

  always_comb begin
    p6    = 31'(s1_prod) * 31'(dsqd_pkg::DIV6_RECIP);
    quo   = p6[30:dsqd_pkg::DIV6_SHIFT];
    scale = (quo > 13'(dsqd_pkg::SCALE_CAP)) ? dsqd_pkg::SCALE_CAP : quo[10:0];

    comb_next = combined_scale;
    flag_next = rebuild_flag;
    taken     = 1'b0;
    if (s1_recomb && (scale != combined_scale)) begin
      comb_next = scale;
      flag_next = 1'b1;
    end
    case (s1_cmd)
      dsqd_pkg::CMD_REQUEST: flag_next = 1'b1;
      dsqd_pkg::CMD_CONSUME: begin
        taken     = rebuild_flag;
        flag_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      combined_scale <= dsqd_pkg::SCALE_RESET;
      rebuild_flag   <= 1'b0;
      res_v          <= 1'b0;
    end else begin
      if (en_o) begin
        res_v <= s1_v;
      end
      if (s1_v && en_o) begin
        combined_scale <= comb_next;
        rebuild_flag   <= flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v && en_o) begin
      res_q.scale_q8      <= comb_next;
      res_q.user_scale_q8 <= s1_user;
      res_q.res_sixths    <= s1_step;
      res_q.rebuild_taken <= taken;
    end
  end

  // ---------------- checks
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    trk.res_step >= dsqd_pkg::STEP_MIN && trk.res_step <= dsqd_pkg::STEP_MAX)
    else $error("resolution step out of range");

  a_scale_cap: assert property (@(posedge clk) disable iff (rst)
    combined_scale <= dsqd_pkg::SCALE_CAP)
    else $error("combined scale above cap");

  a_pending_set: assert property (@(posedge clk) disable iff (rst)
    trk.held_count != 8'd0 |-> trk.pending_step >= dsqd_pkg::STEP_MIN)
    else $error("count held without a pending step");

  a_consume_clears: assert property (@(posedge clk) disable iff (rst)
    s1_v && en_o && s1_cmd == dsqd_pkg::CMD_CONSUME |=> !rebuild_flag)
    else $error("rebuild flag survived a consume");

endmodule

// File: rtl/core/dsqd_track.sv
module dsqd_track (
  input  logic [dsqd_pkg::HEIGHT_BITS-1:0] height_px,
  input  dsqd_pkg::track_t                 cur,
  input  logic [7:0]                       settle,
  output dsqd_pkg::track_t                 nxt,
  output logic                             adopt
);

  localparam logic [dsqd_pkg::HEIGHT_BITS-1:0] H_LO =
    dsqd_pkg::HEIGHT_BITS'(dsqd_pkg::H_MIN);
  localparam logic [dsqd_pkg::HEIGHT_BITS-1:0] H_HI =
    dsqd_pkg::HEIGHT_BITS'(dsqd_pkg::H_MAX);

  logic [11:0] h_cl;
  logic [4:0]  q;
  logic [11:0] cur_px;
  logic [11:0] diff;
  logic [4:0]  cand;
  logic [7:0]  hc_inc;

  always_comb begin
    if (height_px < H_LO) begin
      h_cl = dsqd_pkg::H_MIN;
    end else if (height_px > H_HI) begin
      h_cl = dsqd_pkg::H_MAX;
    end else begin
      h_cl = height_px[11:0];
    end
  end

  // round half up: largest step whose lower midpoint the height reaches
  always_comb begin
    q = dsqd_pkg::STEP_MIN;
    for (int k = 4; k <= 18; k++) begin
      if (h_cl >= dsqd_pkg::step_px(5'(k)) - dsqd_pkg::HALF_PX) begin
        q = 5'(k);
      end
    end
  end

  always_comb begin
    cur_px = dsqd_pkg::step_px(cur.res_step);
    if (h_cl >= cur_px) begin
      diff = h_cl - cur_px;
    end else begin
      diff = cur_px - h_cl;
    end
    cand = (diff < dsqd_pkg::HYST_PX) ? cur.res_step : q;
  end

  always_comb begin
    nxt    = cur;
    adopt  = 1'b0;
    hc_inc = cur.held_count + 8'd1;
    if (height_px != '0) begin
      if (cand == cur.res_step) begin
        nxt.held_count = 8'd0;
      end else if (cand != cur.pending_step) begin
        nxt.pending_step = cand;
        nxt.held_count   = 8'd1;
      end else if (hc_inc < settle) begin
        nxt.held_count = hc_inc;
      end else begin
        nxt.held_count = 8'd0;
        nxt.res_step   = cand;
        adopt          = 1'b1;
      end
    end
  end

endmodule

// File: dv/display_scale_quantizer_debounce_core_tb.sv
module display_scale_quantizer_debounce_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PX_PER_STEP = 180;
  localparam int          HOLD_CYCLES = 64;
  localparam int          IDLE_PCT    = 26;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CHECK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    dsqd_pkg::item_t   it;
    dsqd_pkg::result_t res;
    logic [1:0]        ridx;
    logic [31:0]       rval;
  } row_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_ready;
  dsqd_pkg::item_t   item         = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  dsqd_pkg::result_t result;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [3:0]        paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;

  // shadow of the block's registers and state
  logic [9:0]  cfg_user_min = dsqd_pkg::USER_MIN_RESET;
  logic [9:0]  cfg_user_max = dsqd_pkg::USER_MAX_RESET;
  logic [7:0]  cfg_settle   = dsqd_pkg::SETTLE_RESET;
  logic [4:0]  step_q       = dsqd_pkg::STEP_RESET;
  logic [4:0]  pend_q       = '0;
  logic [7:0]  held_q       = '0;
  logic [9:0]  user_q       = dsqd_pkg::USER_RESET;
  logic [10:0] scale_q      = dsqd_pkg::SCALE_RESET;
  logic        rebuild_q    = 1'b0;

  dsqd_pkg::result_t pending_results[$];
  row_t              rows[$];
  int                errors       = 0;
  bit                no_idle      = 1'b0;
  int                holds_asked  = 0;
  int                holds_done   = 0;

  display_scale_quantizer_debounce_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  task automatic refresh_scale();
    int unsigned s;
    s = (32'(step_q) * 32'(user_q)) / 6;
    if (s > dsqd_pkg::SCALE_CAP) s = dsqd_pkg::SCALE_CAP;
    if (s != 32'(scale_q)) begin
      scale_q   = 11'(s);
      rebuild_q = 1'b1;
    end
  endtask

  task automatic track_height(input logic [dsqd_pkg::HEIGHT_BITS-1:0] h_raw);
    int unsigned h, cand, cur, diff;
    h = 32'(h_raw);
    if (h == 0) return;
    if (h < dsqd_pkg::H_MIN) h = dsqd_pkg::H_MIN;
    if (h > dsqd_pkg::H_MAX) h = dsqd_pkg::H_MAX;
    cand = (h + dsqd_pkg::HALF_PX) / PX_PER_STEP;
    cur  = 32'(step_q) * PX_PER_STEP;
    diff = (h >= cur) ? h - cur : cur - h;
    // hysteresis: stay on the current step when close to it
    if (diff < dsqd_pkg::HYST_PX) cand = step_q;
    if (cand == 32'(step_q)) begin
      held_q = '0;
      return;
    end
    if (cand != 32'(pend_q)) begin
      pend_q = 5'(cand);
      held_q = 8'd1;
      return;
    end
    held_q = held_q + 8'd1;
    if (held_q < cfg_settle) return;
    held_q = '0;
    step_q = 5'(cand);
    refresh_scale();
  endtask

  task automatic track_user(input logic [9:0] v);
    logic [9:0] s;
    s = v;
    // raise first, then lower: a crossed pair leaves the maximum in charge
    if (s < cfg_user_min) s = cfg_user_min;
    if (s > cfg_user_max) s = cfg_user_max;
    if (s == user_q) return;
    user_q = s;
    refresh_scale();
  endtask

  task automatic predict_result(input dsqd_pkg::item_t it, output dsqd_pkg::result_t r);
    logic taken;
    taken = 1'b0;
    case (it.cmd)
      dsqd_pkg::CMD_VIEWPORT: track_height(it.height_px);
      dsqd_pkg::CMD_SET_USER: track_user(it.user_value_q8);
      dsqd_pkg::CMD_REQUEST:  rebuild_q = 1'b1;
      dsqd_pkg::CMD_CONSUME: begin
        taken     = rebuild_q;
        rebuild_q = 1'b0;
      end
      default: ;
    endcase
    r = '{scale_q8: scale_q, user_scale_q8: user_q, res_sixths: step_q, rebuild_taken: taken};
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    dsqd_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, expected none, actual %h",
                 $time, result);
      end else begin
        want = pending_results.pop_front();
        check_field("scale_q8", 32'(want.scale_q8), 32'(result.scale_q8));
        check_field("user_scale_q8", 32'(want.user_scale_q8), 32'(result.user_scale_q8));
        check_field("res_sixths", 32'(want.res_sixths), 32'(result.res_sixths));
        check_field("rebuild_taken", 32'(want.rebuild_taken), 32'(result.rebuild_taken));
      end
    end
  end

  // result side: random stalls, steady stretches and requested long hold-offs
  initial begin
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_done++;
      end else if (no_idle) begin
        result_ready <= 1'b1;
      end else begin
        result_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic push_item(input dsqd_pkg::item_t it, input bit fixed,
                           input dsqd_pkg::result_t fixed_res);
    int gap;
    dsqd_pkg::result_t pred;
    gap = 0;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_result(it, pred);
    pending_results.push_back(fixed ? fixed_res : pred);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      dsqd_pkg::REG_USER_MIN: cfg_user_min = val[9:0];
      dsqd_pkg::REG_USER_MAX: cfg_user_max = val[9:0];
      dsqd_pkg::REG_SETTLE:   cfg_settle   = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_limits(input int lo, input int hi, input int settle);
    apb_write(dsqd_pkg::REG_USER_MIN, {22'($urandom), 10'(lo)});
    apb_write(dsqd_pkg::REG_USER_MAX, {22'($urandom), 10'(hi)});
    apb_write(dsqd_pkg::REG_SETTLE, {24'($urandom), 8'(settle)});
  endtask

  function automatic row_t mk_item(logic [1:0] cmd, int h, int u, int s = -1, int us = 0,
                                   int st = 0, int tk = 0);
    row_t r;
    r.kind = (s < 0) ? ROW_ITEM : ROW_CHECK;
    r.it   = '{cmd: cmd, height_px: dsqd_pkg::HEIGHT_BITS'(h), user_value_q8: 10'(u)};
    r.res  = '{scale_q8: 11'(s), user_scale_q8: 10'(us), res_sixths: 5'(st),
               rebuild_taken: 1'(tk)};
    r.ridx = '0;
    r.rval = '0;
    return r;
  endfunction

  function automatic row_t mk_cfg(logic [1:0] idx, logic [31:0] val);
    row_t r;
    r      = mk_item(dsqd_pkg::CMD_REQUEST, 0, 0);
    r.kind = ROW_CFG;
    r.ridx = idx;
    r.rval = val;
    return r;
  endfunction

  function automatic logic [dsqd_pkg::HEIGHT_BITS-1:0] pick_height();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4)  return '0;
    if (r < 14) return dsqd_pkg::HEIGHT_BITS'($urandom_range(539, 1));
    if (r < 86) return dsqd_pkg::HEIGHT_BITS'($urandom_range(3240, 540));
    return dsqd_pkg::HEIGHT_BITS'($urandom_range(16383, 3241));
  endfunction

  function automatic dsqd_pkg::item_t noise_item();
    dsqd_pkg::item_t it;
    it.cmd           = 2'($urandom_range(3));
    it.height_px     = dsqd_pkg::HEIGHT_BITS'($urandom_range(16383));
    it.user_value_q8 = 10'($urandom_range(1023));
    return it;
  endfunction

  function automatic dsqd_pkg::item_t viewport_item(logic [dsqd_pkg::HEIGHT_BITS-1:0] h);
    dsqd_pkg::item_t it;
    it               = noise_item();
    it.cmd           = dsqd_pkg::CMD_VIEWPORT;
    it.height_px     = h;
    return it;
  endfunction

  // mostly runs of matching viewport reports long enough to settle, some
  // cut short, the rest arbitrary items
  task automatic run_phase(input int n_items);
    int sent, len, k, s;
    int unsigned r;
    logic [dsqd_pkg::HEIGHT_BITS-1:0] tgt, h;
    dsqd_pkg::result_t none;
    none = '0;
    sent = 0;
    while (sent < n_items) begin
      r   = $urandom_range(99);
      s   = int'(cfg_settle);
      tgt = pick_height();
      if (r < 55)      len = s + 1 + $urandom_range(2);
      else if (r < 80) len = 0;
      else             len = $urandom_range((s > 1) ? s - 1 : 1, 1);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(99) < 12) begin
          push_item(noise_item(), 1'b0, none);
          sent++;
        end
        h = ($urandom_range(9) < 7) ? tgt : tgt ^ dsqd_pkg::HEIGHT_BITS'($urandom_range(7));
        push_item(viewport_item(h), 1'b0, none);
        sent++;
      end
      if (r >= 80) push_item(viewport_item(pick_height()), 1'b0, none);
      else if (len == 0) push_item(noise_item(), 1'b0, none);
      if (r >= 55) sent++;
    end
  endtask

  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stim
    // reset defaults: min 128, max 448, settle 12, step 6, scale 320
    rows.push_back(mk_item(dsqd_pkg::CMD_CONSUME, 0, 0, 320, 320, 6, 0));
    rows.push_back(mk_item(dsqd_pkg::CMD_REQUEST, 0, 0, 320, 320, 6, 0));
    rows.push_back(mk_item(dsqd_pkg::CMD_CONSUME, 0, 0, 320, 320, 6, 1));
    rows.push_back(mk_item(dsqd_pkg::CMD_CONSUME, 0, 0, 320, 320, 6, 0));
    // zero height ignored
    rows.push_back(mk_item(dsqd_pkg::CMD_VIEWPORT, 0, 1023, 320, 320, 6, 0));
    rows.push_back(mk_item(dsqd_pkg::CMD_SET_USER, 16383, 1023, 448, 448, 6, 0));
    rows.push_back(mk_item(dsqd_pkg::CMD_SET_USER, 0, 0, 128, 128, 6, 0));
    rows.push_back(mk_item(dsqd_pkg::CMD_CONSUME, 0, 0, 128, 128, 6, 1));
    rows.push_back(mk_cfg(dsqd_pkg::REG_SETTLE, 32'd10));
    rows.push_back(mk_item(dsqd_pkg::CMD_VIEWPORT, 16383, 0, 128, 128, 6, 0));
    rows.push_back(mk_item(dsqd_pkg::CMD_VIEWPORT, 3240, 0, 128, 128, 6, 0));
    rows.push_back(mk_item(dsqd_pkg::CMD_VIEWPORT, 3300, 0, 128, 128, 6, 0));
    // lowered settle count: next matching report adopts at once
    rows.push_back(mk_cfg(dsqd_pkg::REG_SETTLE, 32'd2));
    rows.push_back(mk_item(dsqd_pkg::CMD_VIEWPORT, 3239, 0, 384, 128, 18, 0));
    // capped at 4.0
    rows.push_back(mk_item(dsqd_pkg::CMD_SET_USER, 0, 448, 1024, 448, 18, 0));
    rows.push_back(mk_item(dsqd_pkg::CMD_VIEWPORT, 3106, 0));  // inside hysteresis
    rows.push_back(mk_item(dsqd_pkg::CMD_VIEWPORT, 3105, 0));  // just outside
    rows.push_back(mk_item(dsqd_pkg::CMD_VIEWPORT, 1170, 0));  // half rounds up
    rows.push_back(mk_item(dsqd_pkg::CMD_VIEWPORT, 1170, 0));
    rows.push_back(mk_item(dsqd_pkg::CMD_VIEWPORT, 1, 0));     // clamps to 540
    rows.push_back(mk_cfg(dsqd_pkg::REG_SETTLE, 32'd0));
    rows.push_back(mk_item(dsqd_pkg::CMD_VIEWPORT, 539, 0));
    rows.push_back(mk_item(dsqd_pkg::CMD_VIEWPORT, 900, 0));
    rows.push_back(mk_item(dsqd_pkg::CMD_VIEWPORT, 900, 0));
    rows.push_back(mk_cfg(dsqd_pkg::REG_USER_MIN, 32'd500));
    rows.push_back(mk_cfg(dsqd_pkg::REG_USER_MAX, 32'd200));   // crossed limits
    rows.push_back(mk_item(dsqd_pkg::CMD_SET_USER, 0, 0));
    rows.push_back(mk_item(dsqd_pkg::CMD_CONSUME, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        apb_write(rows[i].ridx, rows[i].rval);
      end else begin
        push_item(rows[i].it, rows[i].kind == ROW_CHECK, rows[i].res);
      end
    end

    drain();
    write_limits(0, 1023, 1);
    run_phase(300);

    drain();
    write_limits(dsqd_pkg::USER_MIN_RESET, dsqd_pkg::USER_MAX_RESET, dsqd_pkg::SETTLE_RESET);
    run_phase(100);
    // steady stretch; the result side holds off so the pipeline backs up
    no_idle = 1'b1;
    holds_asked++;
    run_phase(150);
    no_idle = 1'b0;
    drain();
    run_phase(150);

    drain();
    write_limits(1023, 0, 0);
    run_phase(250);

    drain();
    write_limits($urandom_range(1023), $urandom_range(1023), 255);
    run_phase(350);

    repeat (4) begin
      drain();
      write_limits($urandom_range(1023), $urandom_range(1023), $urandom_range(24, 1));
      run_phase(90);
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: display_scale_quantizer_debounce_core.f
rtl/core/dsqd_pkg.sv
rtl/core/dsqd_track.sv
rtl/core/display_scale_quantizer_debounce_core.sv
dv/display_scale_quantizer_debounce_core_tb.sv
